### hdl/blp_pkg.sv
// Shared types and defaults for the line point generator.
// No dependencies; used by blp_setup, blp_walker and bresenham_line_points.
package blp_pkg;

  // Default coordinate width in bits
  localparam int unsigned COORD_BITS_DEF = 12;

  // Item kind carried on the input tuser bit
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } blp_mode_e;

  // Octant transform of the active line
  typedef struct packed {
    logic axes_swapped;
    logic x_mirrored;
    logic index_descending;
  } blp_flags_t;

endpackage

### hdl/blp_setup.sv
// Line setup: octant transform, deltas, start point and error increments.
// Purely combinational; depends on blp_pkg for the flag bundle.
module blp_setup #(
  parameter int unsigned COORD_BITS = blp_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]        start_x_i,
  input  logic [COORD_BITS-1:0]        start_y_i,
  input  logic [COORD_BITS-1:0]        end_x_i,
  input  logic [COORD_BITS-1:0]        end_y_i,
  output blp_pkg::blp_flags_t          flags_o,
  output logic [COORD_BITS-1:0]        major_o,
  output logic [COORD_BITS-1:0]        minor_o,
  output logic signed [COORD_BITS+2:0] err_o,
  output logic [COORD_BITS+1:0]        inc_flat_o,
  output logic signed [COORD_BITS+2:0] inc_diag_o,
  output logic [COORD_BITS:0]          npix_o,
  output logic [COORD_BITS-1:0]        slot_o
);

  localparam int unsigned C = COORD_BITS;

  logic signed [C:0]   dx, dy;
  logic [C:0]          ndx, ndy;
  logic [C-1:0]        adx, ady;
  logic [C-1:0]        d_major, d_minor;
  logic                mirror, swap, desc;
  logic [C-1:0]        sel_x, sel_y, sel_xt;

  // Signed deltas and their magnitudes
  assign dx  = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
  assign dy  = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[C] ? ndx[C-1:0] : dx[C-1:0];
  assign ady = dy[C] ? ndy[C-1:0] : dy[C-1:0];

  // Mirror on negative slope, swap on steep lines
  assign mirror = ((dx > 0) && (dy < 0)) || ((dx <= 0) && (dy > 0));
  assign swap   = adx < ady;
  assign d_major = swap ? ady : adx;
  assign d_minor = swap ? adx : ady;

  // Walk from the endpoint with the lower transformed major coordinate
  always_comb begin
    if (swap) begin
      desc = start_y_i > end_y_i;
    end else if (mirror) begin
      desc = start_x_i < end_x_i;
    end else begin
      desc = start_x_i > end_x_i;
    end
  end

  assign sel_x  = desc ? end_x_i : start_x_i;
  assign sel_y  = desc ? end_y_i : start_y_i;
  assign sel_xt = mirror ? (~sel_x + 1'b1) : sel_x;

  assign major_o = swap ? sel_y : sel_xt;
  assign minor_o = swap ? sel_xt : sel_y;

  // Error term and increments
  assign err_o      = $signed({2'b00, d_minor, 1'b0}) - $signed({3'b000, d_major});
  assign inc_flat_o = {d_minor, 1'b0};
  assign inc_diag_o = $signed({2'b00, d_minor, 1'b0}) - $signed({2'b00, d_major, 1'b0});
  assign npix_o     = {1'b0, d_major} + 1'b1;
  assign slot_o     = desc ? d_major : '0;

  assign flags_o.axes_swapped     = swap;
  assign flags_o.x_mirrored       = mirror;
  assign flags_o.index_descending = desc;

endmodule

### hdl/blp_walker.sv
// Walk state, per-pixel step and the output word register.
// Depends on blp_pkg; fed by blp_setup through the top level.
module blp_walker #(
  parameter int unsigned COORD_BITS = blp_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  input  blp_pkg::blp_mode_e           item_mode_i,
  output logic                         item_taken_o,
  input  blp_pkg::blp_flags_t          flags_i,
  input  logic [COORD_BITS-1:0]        major_i,
  input  logic [COORD_BITS-1:0]        minor_i,
  input  logic signed [COORD_BITS+2:0] err_i,
  input  logic [COORD_BITS+1:0]        inc_flat_i,
  input  logic signed [COORD_BITS+2:0] inc_diag_i,
  input  logic [COORD_BITS:0]          npix_i,
  input  logic [COORD_BITS-1:0]        slot_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [COORD_BITS-1:0]        out_slot_o,
  output logic [COORD_BITS-1:0]        out_x_o,
  output logic [COORD_BITS-1:0]        out_y_o,
  output logic                         out_last_o
);

  localparam int unsigned C = COORD_BITS;

  blp_pkg::blp_flags_t flags_q;
  logic [C-1:0]        major_q, minor_q, slot_q;
  logic signed [C+2:0] err_q;
  logic [C+1:0]        inc_flat_q;
  logic signed [C+2:0] inc_diag_q;
  logic [C:0]          left_q;

  logic                out_valid_q;
  logic [C-1:0]        out_slot_q, out_x_q, out_y_q;
  logic                out_last_q;

  logic                busy, produces, out_free, load_fire, step_fire;
  logic [C-1:0]        px, py, px_m;

  // Handshake between the item register and the output word
  assign busy      = left_q != '0;
  assign produces  = (item_mode_i == blp_pkg::MODE_STEP) && busy;
  assign out_free  = !out_valid_q || out_ready_i;
  assign item_taken_o = item_valid_i && (!produces || out_free);
  assign load_fire = item_valid_i && (item_mode_i == blp_pkg::MODE_LOAD);
  assign step_fire = item_valid_i && produces && out_free;

  // Undo the octant transform for the current pixel
  assign px   = flags_q.axes_swapped ? minor_q : major_q;
  assign py   = flags_q.axes_swapped ? major_q : minor_q;
  assign px_m = flags_q.x_mirrored ? (~px + 1'b1) : px;

  // Load a new line or advance one pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      major_q    <= '0;
      minor_q    <= '0;
      err_q      <= '0;
      inc_flat_q <= '0;
      inc_diag_q <= '0;
      slot_q     <= '0;
      left_q     <= '0;
    end else if (load_fire) begin
      flags_q    <= flags_i;
      major_q    <= major_i;
      minor_q    <= minor_i;
      err_q      <= err_i;
      inc_flat_q <= inc_flat_i;
      inc_diag_q <= inc_diag_i;
      slot_q     <= slot_i;
      left_q     <= npix_i;
    end else if (step_fire) begin
      major_q <= major_q + 1'b1;
      if (err_q < 0) begin
        err_q <= err_q + $signed({1'b0, inc_flat_q});
      end else begin
        minor_q <= minor_q + 1'b1;
        err_q   <= err_q + inc_diag_q;
      end
      slot_q <= flags_q.index_descending ? (slot_q - 1'b1) : (slot_q + 1'b1);
      left_q <= left_q - 1'b1;
    end
  end

  // Output word valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_slot_q <= slot_q;
      out_x_q    <= px_m;
      out_y_q    <= py;
      out_last_q <= left_q == {{C{1'b0}}, 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_slot_o  = out_slot_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_last_o  = out_last_q;

  // A pixel is only emitted from an active line
  a_step_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |-> busy)
    else $error("pixel emitted with no active line");

  // Each emitted pixel uses up one count
  a_count_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> left_q == $past(left_q) - 1'b1)
    else $error("pixel count did not decrement");

  // The last pixel leaves the walker idle
  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && (left_q == {{C{1'b0}}, 1'b1})) |=> !busy)
    else $error("walker still busy after last pixel");

  // A held output word is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !step_fire)
    else $error("output word overwritten while stalled");

endmodule

### hdl/bresenham_line_points.sv
// Top level of the line point generator: input word register, setup, walker.
// Depends on blp_pkg, blp_setup and blp_walker.
// A step word passes the input register, then the output register, to the master side;
//   a load word passes the input register into the walk state. Each step is one add and
//   compare on the error term. Throughput: one word per cycle unless the master stalls.
// Reset: asynchronous, active low; clears valid flags and the walk, so the block is idle.
module bresenham_line_points #(
  parameter int unsigned COORD_BITS = blp_pkg::COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // tuser: mode
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: start_x, start_y, end_x, end_y (lowest bits first)
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: slot_index, point_x, point_y (lowest bits first); tlast: last_point
  output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  localparam int unsigned C = COORD_BITS;

  logic                in_valid_q;
  blp_pkg::blp_mode_e  mode_q;
  logic [C-1:0]        sx_q, sy_q, ex_q, ey_q;
  logic                item_taken, in_fire;

  blp_pkg::blp_flags_t flags;
  logic [C-1:0]        major, minor, slot;
  logic signed [C+2:0] err, inc_diag;
  logic [C+1:0]        inc_flat;
  logic [C:0]          npix;
  logic [C-1:0]        o_slot, o_x, o_y;

  // Accept a word when the input register is empty or draining
  assign s_axis_tready = !in_valid_q || item_taken;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Hold the input payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= blp_pkg::blp_mode_e'(s_axis_tuser);
      sx_q   <= s_axis_tdata[C-1:0];
      sy_q   <= s_axis_tdata[2*C-1:C];
      ex_q   <= s_axis_tdata[3*C-1:2*C];
      ey_q   <= s_axis_tdata[4*C-1:3*C];
    end
  end

  blp_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_x_i  (sx_q),
    .start_y_i  (sy_q),
    .end_x_i    (ex_q),
    .end_y_i    (ey_q),
    .flags_o    (flags),
    .major_o    (major),
    .minor_o    (minor),
    .err_o      (err),
    .inc_flat_o (inc_flat),
    .inc_diag_o (inc_diag),
    .npix_o     (npix),
    .slot_o     (slot)
  );

  blp_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_mode_i  (mode_q),
    .item_taken_o (item_taken),
    .flags_i      (flags),
    .major_i      (major),
    .minor_i      (minor),
    .err_i        (err),
    .inc_flat_i   (inc_flat),
    .inc_diag_i   (inc_diag),
    .npix_i       (npix),
    .slot_i       (slot),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_slot_o   (o_slot),
    .out_x_o      (o_x),
    .out_y_o      (o_y),
    .out_last_o   (m_axis_tlast)
  );

  // Pack the output word, zero padded
  always_comb begin
    m_axis_tdata          = '0;
    m_axis_tdata[3*C-1:0] = {o_y, o_x, o_slot};
  end

endmodule

### tb/sv/bresenham_line_points_tb.sv
// Self-checking testbench for the line point generator: directed rows, then random lines.
// Depends on blp_pkg and bresenham_line_points; holds its own pixel predictor.
`timescale 1ns / 100ps

module bresenham_line_points_tb;

  localparam int CW           = blp_pkg::COORD_BITS_DEF;
  localparam int S_W          = ((4*CW+7)/8)*8;
  localparam int M_W          = ((3*CW+7)/8)*8;
  localparam int CMAX         = (1 << CW) - 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1880;
  localparam int NUM_DIRECTED = 25;

  typedef struct packed {
    logic [CW-1:0] slot;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } pixel_t;

  typedef struct packed {
    blp_pkg::blp_mode_e mode;
    logic [CW-1:0]      sx, sy, ex, ey;
    logic               fixed;
    pixel_t             want;
  } dir_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [S_W-1:0] s_axis_tdata;
  logic           s_axis_tuser;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [M_W-1:0] m_axis_tdata;
  logic           m_axis_tlast;

  // Pixels predicted but not yet seen on the master side
  pixel_t pending_pixels[$];
  int     fail_count  = 0;
  int     cycle_count = 0;
  bit     steady_run  = 1'b0;

  // Predictor copy of the walk state
  int            line_major   = 0;
  int            line_minor   = 0;
  int            line_err     = 0;
  int            err_hold     = 0;
  int            err_move     = 0;
  logic [CW-1:0] slot_next    = '0;
  logic [CW:0]   pixels_to_go = '0;
  bit            swap_axes    = 1'b0;
  bit            mirror_x     = 1'b0;
  bit            count_down   = 1'b0;

  dir_row_t directed_rows [NUM_DIRECTED];

  bresenham_line_points uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Apply one accepted word to the predicted walk; return 1 when it yields a pixel
  function automatic bit rasterize_word(input blp_pkg::blp_mode_e mode,
                                        input logic [CW-1:0] sx, sy, ex, ey,
                                        output pixel_t pix);
    int x1, y1, x2, y2, dx, dy, t, px, py;
    pix = '0;
    if (mode == blp_pkg::MODE_LOAD) begin
      x1 = int'(sx);
      y1 = int'(sy);
      x2 = int'(ex);
      y2 = int'(ey);
      dx = x2 - x1;
      dy = y2 - y1;
      // Bring the line into the first octant
      mirror_x = (dx > 0 && dy < 0) || (dx <= 0 && dy > 0);
      if (mirror_x) begin
        x1 = -x1;
        x2 = -x2;
      end
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      swap_axes = (dx < dy);
      if (swap_axes) begin
        t = x1; x1 = y1; y1 = t;
        t = x2; x2 = y2; y2 = t;
        t = dx; dx = dy; dy = t;
      end
      line_err     = 2 * dy - dx;
      err_hold     = 2 * dy;
      err_move     = 2 * (dy - dx);
      pixels_to_go = (CW+1)'(dx + 1);
      // Walk from the endpoint with the lower major coordinate
      if (x1 > x2) begin
        line_major = x2;
        line_minor = y2;
        slot_next  = CW'(dx);
        count_down = 1'b1;
      end else begin
        line_major = x1;
        line_minor = y1;
        slot_next  = '0;
        count_down = 1'b0;
      end
      return 1'b0;
    end
    if (pixels_to_go == 0) return 1'b0;

    // Undo the octant transform for the current pixel
    px = swap_axes ? line_minor : line_major;
    py = swap_axes ? line_major : line_minor;
    if (mirror_x) px = -px;
    pix.slot = slot_next;
    pix.x    = px[CW-1:0];
    pix.y    = py[CW-1:0];
    pix.last = (pixels_to_go == 1);

    // Advance the walk
    line_major = line_major + 1;
    if (line_err < 0) begin
      line_err = line_err + err_hold;
    end else begin
      line_minor = line_minor + 1;
      line_err   = line_err + err_move;
    end
    slot_next    = count_down ? slot_next - 1'b1 : slot_next + 1'b1;
    pixels_to_go = pixels_to_go - 1'b1;
    return 1'b1;
  endfunction

  // Pick an endpoint coordinate a short distance from c, inside the grid
  function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] c);
    int d, e;
    d = int'($urandom_range(0, 48)) - 24;
    e = int'(c) + d;
    if (e < 0 || e > CMAX) e = int'(c) - d;
    return e[CW-1:0];
  endfunction

  // Send one word with random gaps; queue the pixel it must produce
  task automatic push_word(input blp_pkg::blp_mode_e mode,
                           input logic [CW-1:0] sx, sy, ex, ey,
                           input logic fixed, input pixel_t want, output bit has_pix);
    pixel_t pix;
    @(negedge clk_i);
    while (!steady_run && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= S_W'({ey, ex, sy, sx});
    do @(posedge clk_i); while (!s_axis_tready);
    has_pix = rasterize_word(mode, sx, sy, ex, ey, pix);
    if (fixed) begin
      pending_pixels.push_back(want);
      has_pix = 1'b1;
    end else if (has_pix) begin
      pending_pixels.push_back(pix);
    end
  endtask

  // Hold the input side until every predicted pixel has come out
  task automatic drain_pixels();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Output side: random backpressure, steady during the no-idle stretch
  always @(negedge clk_i) begin
    m_axis_tready <= steady_run || ($urandom_range(0, 99) >= 25);
  end

  // Compare each pixel word with the oldest prediction
  always @(posedge clk_i) begin
    pixel_t exp_pix;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word: slot %0d x %0d y %0d last %0b",
               m_axis_tdata[CW-1:0], m_axis_tdata[2*CW-1:CW], m_axis_tdata[3*CW-1:2*CW],
               m_axis_tlast);
        fail_count++;
      end else begin
        exp_pix = pending_pixels.pop_front();
        if (m_axis_tdata[CW-1:0] !== exp_pix.slot) begin
          $error("slot_index: expected %0d, got %0d", exp_pix.slot, m_axis_tdata[CW-1:0]);
          fail_count++;
        end
        if (m_axis_tdata[2*CW-1:CW] !== exp_pix.x) begin
          $error("point_x: expected %0d, got %0d", exp_pix.x, m_axis_tdata[2*CW-1:CW]);
          fail_count++;
        end
        if (m_axis_tdata[3*CW-1:2*CW] !== exp_pix.y) begin
          $error("point_y: expected %0d, got %0d", exp_pix.y, m_axis_tdata[3*CW-1:2*CW]);
          fail_count++;
        end
        if (m_axis_tlast !== exp_pix.last) begin
          $error("last_point: expected %0b, got %0b", exp_pix.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int                 counted;
    int                 next_pause;
    int                 kind;
    int                 steps;
    int                 dx, dy;
    bit                 has_pix;
    blp_pkg::blp_mode_e mode;
    logic [CW-1:0]      sx, sy, ex, ey;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_ni        = 1'b0;

    // Directed rows: idle steps, single-pixel lines, corners, diagonals, steep and flat lines
    directed_rows = '{
      '{blp_pkg::MODE_STEP, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, '0},
      '{blp_pkg::MODE_LOAD, 12'd5,    12'd7,    12'd5,    12'd7,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1,
        '{12'd0, 12'd5, 12'd7, 1'b1}},
      '{blp_pkg::MODE_STEP, 12'd4095, 12'd0,    12'd4095, 12'd0,    1'b0, '0},
      '{blp_pkg::MODE_LOAD, 12'd0,    12'd0,    12'd4095, 12'd4095, 1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1,
        '{12'd0, 12'd0, 12'd0, 1'b0}},
      '{blp_pkg::MODE_STEP, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1,
        '{12'd1, 12'd1, 12'd1, 1'b0}},
      '{blp_pkg::MODE_LOAD, 12'd4095, 12'd0,    12'd0,    12'd4095, 1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_LOAD, 12'd0,    12'd4095, 12'd4095, 12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_LOAD, 12'd100,  12'd10,   12'd90,   12'd200,  1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_LOAD, 12'd4095, 12'd4095, 12'd4094, 12'd4095, 1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_LOAD, 12'd0,    12'd4095, 12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b0, '0},
      '{blp_pkg::MODE_LOAD, 12'd4095, 12'd0,    12'd4095, 12'd0,    1'b0, '0},
      '{blp_pkg::MODE_STEP, 12'd0,    12'd0,    12'd0,    12'd0,    1'b1,
        '{12'd0, 12'd4095, 12'd0, 1'b1}}
    };

    // Hold reset, then release it
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      push_word(directed_rows[i].mode, directed_rows[i].sx, directed_rows[i].sy,
                directed_rows[i].ex, directed_rows[i].ey, directed_rows[i].fixed,
                directed_rows[i].want, has_pix);
    end
    drain_pixels();

    // Random lines: mostly short, fully walked; some cut short or far apart; some noise
    counted    = 0;
    next_pause = 400;
    while (counted < RANDOM_ITEMS) begin
      steady_run = (counted >= 800 && counted < 1100);
      if (counted >= next_pause) begin
        drain_pixels();
        next_pause += 400;
      end
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        mode = blp_pkg::blp_mode_e'($urandom_range(0, 1));
        push_word(mode, CW'($urandom()), CW'($urandom()), CW'($urandom()), CW'($urandom()),
                  1'b0, '0, has_pix);
        if (has_pix || mode == blp_pkg::MODE_LOAD) counted++;
      end else begin
        sx = CW'($urandom());
        sy = CW'($urandom());
        if (kind < 16) begin
          ex = CW'($urandom());
          ey = CW'($urandom());
        end else begin
          ex = near_coord(sx);
          ey = near_coord(sy);
        end
        push_word(blp_pkg::MODE_LOAD, sx, sy, ex, ey, 1'b0, '0, has_pix);
        counted++;
        dx = int'(ex) - int'(sx);
        dy = int'(ey) - int'(sy);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (kind < 16) steps = $urandom_range(0, 40);
        else if ($urandom_range(0, 99) < 80) steps = (dx > dy ? dx : dy) + 1 +
                                                      $urandom_range(0, 2);
        else steps = $urandom_range(0, (dx > dy ? dx : dy) + 1);
        repeat (steps) begin
          push_word(blp_pkg::MODE_STEP, CW'($urandom()), CW'($urandom()), CW'($urandom()),
                    CW'($urandom()), 1'b0, '0, has_pix);
          if (has_pix) counted++;
        end
      end
    end
    steady_run = 1'b0;

    // Let the last words settle
    drain_pixels();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
